[sv/rtph_pkg.sv]
package rtph_pkg;

    localparam int QueueDepth = 2;

    localparam logic [3:0] K_HEADER  = 4'd0;
    localparam logic [3:0] K_CSRC    = 4'd1;
    localparam logic [3:0] K_ELEM    = 4'd2;
    localparam logic [3:0] K_EBYTE   = 4'd3;
    localparam logic [3:0] K_PAY     = 4'd4;
    localparam logic [3:0] K_END     = 4'd5;
    localparam logic [3:0] K_BADVER  = 4'd6;
    localparam logic [3:0] K_BADPROF = 4'd7;
    localparam logic [3:0] K_TRUNC   = 4'd8;

    localparam logic [15:0] EXT_PROFILE = 16'hBEDE;

    // one record, as queued between front and back
    typedef struct packed {
        logic [3:0]  rec_kind;
        logic        extension_flag;
        logic [3:0]  csrc_count;
        logic        marker;
        logic [6:0]  payload_type;
        logic [15:0] sequence_res;
        logic [31:0] timestamp;
        logic [31:0] source_id;
        logic [3:0]  ext_id;
        logic [4:0]  ext_len;
        logic [7:0]  data_byte;
    } rec_t;

    // up to two records caused by one input word
    typedef struct packed {
        logic second_valid;
        rec_t first;
        rec_t second;
    } pair_t;

endpackage

[sv/rtp_header_parser.sv]
// channel | direction | handshake           | payload
// input   | in        | in_valid/in_ready   | in_byte, end_of_packet
// output  | out       | out_valid/out_ready | rec_kind .. data_byte, last
//
// One input word per cycle while the record stream keeps up; a word making two
// records (a final byte with its end or truncated record) presents both in turn.
// The front classifier registers each word's records; a two-entry queue
// lets the record stream stall without stopping the byte stream at once.
// rst_n clears parse state and queue; no clearing pass is needed.
module rtp_header_parser
    import rtph_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    input  logic        end_of_packet,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  rec_kind,
    output logic        extension_flag,
    output logic [3:0]  csrc_count,
    output logic        marker,
    output logic [6:0]  payload_type,
    output logic [15:0] sequence_res,
    output logic [31:0] timestamp,
    output logic [31:0] source_id,
    output logic [3:0]  ext_id,
    output logic [4:0]  ext_len,
    output logic [7:0]  data_byte,
    output logic        last
);

    logic  pair_valid;
    logic  pair_ready;
    pair_t pair_data;

    rtph_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_byte       (in_byte),
        .end_of_packet (end_of_packet),
        .pair_valid    (pair_valid),
        .pair_ready    (pair_ready),
        .pair_data     (pair_data)
    );

    rtph_back #(.DEPTH(DEPTH)) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pair_valid     (pair_valid),
        .pair_ready     (pair_ready),
        .pair_data      (pair_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .rec_kind       (rec_kind),
        .extension_flag (extension_flag),
        .csrc_count     (csrc_count),
        .marker         (marker),
        .payload_type   (payload_type),
        .sequence_res   (sequence_res),
        .timestamp      (timestamp),
        .source_id      (source_id),
        .ext_id         (ext_id),
        .ext_len        (ext_len),
        .data_byte      (data_byte),
        .last           (last)
    );

endmodule

[sv/rtph_front.sv]
module rtph_front
    import rtph_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] in_byte,
    input  logic       end_of_packet,
    output logic       pair_valid,
    input  logic       pair_ready,
    output pair_t      pair_data
);

    localparam logic [2:0] PH_FIXED   = 3'd0;
    localparam logic [2:0] PH_CSRC    = 3'd1;
    localparam logic [2:0] PH_EXTHDR  = 3'd2;
    localparam logic [2:0] PH_ELEM    = 3'd3;
    localparam logic [2:0] PH_EDATA   = 3'd4;
    localparam logic [2:0] PH_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_DROP    = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  offset_reg, offset_next;
    logic [31:0] shift_reg, shift_next;
    logic [15:0] seq_reg, seq_next;
    logic [31:0] stamp_reg, stamp_next;
    logic [15:0] first_reg, first_next;
    logic [3:0]  csrc_left_reg, csrc_left_next;
    logic [17:0] ext_left_reg, ext_left_next;
    logic [4:0]  elem_left_reg, elem_left_next;
    logic        stopped_reg, stopped_next;

    logic        out_valid_reg;
    pair_t       out_reg;
    logic        go;
    logic        n_any;
    pair_t       pr;
    logic        have_first;
    logic [2:0]  after_csrc;
    logic [31:0] sh;
    rec_t        rec_a;
    rec_t        rec_b;
    logic        has_a;
    logic        has_b;
    logic        err;

    assign in_ready   = !out_valid_reg || pair_ready;
    assign go         = in_valid && in_ready;
    assign pair_valid = out_valid_reg;
    assign pair_data  = out_reg;
    assign after_csrc = first_reg[12] ? PH_EXTHDR : PH_PAYLOAD;
    assign sh         = {shift_reg[23:0], in_byte};

    always_comb
    begin
        phase_next     = phase_reg;
        offset_next    = offset_reg;
        shift_next     = shift_reg;
        seq_next       = seq_reg;
        stamp_next     = stamp_reg;
        first_next     = first_reg;
        csrc_left_next = csrc_left_reg;
        ext_left_next  = ext_left_reg;
        elem_left_next = elem_left_reg;
        stopped_next   = stopped_reg;
        rec_a          = '0;
        rec_b          = '0;
        has_a          = 1'b0;
        has_b          = 1'b0;
        err            = 1'b0;
        unique case (phase_reg)
            PH_FIXED:
            begin
                shift_next = sh;
                if (offset_reg == 4'd0 && in_byte[7:6] != 2'd2)
                begin
                    has_a          = 1'b1;
                    rec_a.rec_kind = K_BADVER;
                    phase_next     = PH_DROP;
                    err            = 1'b1;
                end
                else
                begin
                    if (offset_reg == 4'd1)
                        first_next = sh[15:0];
                    if (offset_reg == 4'd3)
                        seq_next = sh[15:0];
                    if (offset_reg == 4'd7)
                        stamp_next = sh;
                    if (offset_reg >= 4'd11)
                    begin
                        has_a                = 1'b1;
                        rec_a.rec_kind       = K_HEADER;
                        rec_a.extension_flag = first_reg[12];
                        rec_a.csrc_count     = first_reg[11:8];
                        rec_a.marker         = first_reg[7];
                        rec_a.payload_type   = first_reg[6:0];
                        rec_a.sequence_res   = seq_reg;
                        rec_a.timestamp      = stamp_reg;
                        rec_a.source_id      = sh;
                        csrc_left_next       = first_reg[11:8];
                        offset_next          = 4'd0;
                        phase_next = (first_reg[11:8] != 4'd0) ? PH_CSRC : after_csrc;
                    end
                    else
                        offset_next = offset_reg + 4'd1;
                end
            end
            PH_CSRC:
            begin
                shift_next = sh;
                if (offset_reg >= 4'd3)
                begin
                    has_a           = 1'b1;
                    rec_a.rec_kind  = K_CSRC;
                    rec_a.source_id = sh;
                    csrc_left_next  = csrc_left_reg - 4'd1;
                    offset_next     = 4'd0;
                    if (csrc_left_reg == 4'd1)
                        phase_next = after_csrc;
                end
                else
                    offset_next = offset_reg + 4'd1;
            end
            PH_EXTHDR:
            begin
                shift_next = sh;
                if (offset_reg == 4'd1 && sh[15:0] != EXT_PROFILE)
                begin
                    has_a          = 1'b1;
                    rec_a.rec_kind = K_BADPROF;
                    phase_next     = PH_DROP;
                    err            = 1'b1;
                end
                else if (offset_reg >= 4'd3)
                begin
                    ext_left_next = {sh[15:0], 2'b00};
                    offset_next   = 4'd0;
                    stopped_next  = 1'b0;
                    phase_next    = (sh[15:0] != 16'd0) ? PH_ELEM : PH_PAYLOAD;
                end
                else
                    offset_next = offset_reg + 4'd1;
            end
            PH_ELEM:
            begin
                ext_left_next = ext_left_reg - 18'd1;
                if (!stopped_reg)
                begin
                    if (in_byte[7:4] == 4'hf)
                        stopped_next = 1'b1;
                    else if (in_byte[7:4] != 4'h0)
                    begin
                        has_a          = 1'b1;
                        rec_a.rec_kind = K_ELEM;
                        rec_a.ext_id   = in_byte[7:4];
                        rec_a.ext_len  = {1'b0, in_byte[3:0]} + 5'd1;
                        elem_left_next = {1'b0, in_byte[3:0]} + 5'd1;
                        phase_next     = PH_EDATA;
                    end
                end
                if (ext_left_reg == 18'd1)
                    phase_next = PH_PAYLOAD;
            end
            PH_EDATA:
            begin
                has_a           = 1'b1;
                rec_a.rec_kind  = K_EBYTE;
                rec_a.data_byte = in_byte;
                ext_left_next   = ext_left_reg - 18'd1;
                elem_left_next  = elem_left_reg - 5'd1;
                if (ext_left_reg == 18'd1)
                    phase_next = PH_PAYLOAD;
                else if (elem_left_reg == 5'd1)
                    phase_next = PH_ELEM;
            end
            PH_PAYLOAD:
            begin
                has_a           = 1'b1;
                rec_a.rec_kind  = K_PAY;
                rec_a.data_byte = in_byte;
            end
            default:
            begin
            end
        endcase

        if (end_of_packet)
        begin
            if (!err && phase_reg != PH_DROP)
            begin
                has_b = 1'b1;
                if (phase_next == PH_PAYLOAD)
                begin
                    rec_b.rec_kind = K_END;
                    if (first_reg[13] && phase_reg == PH_PAYLOAD)
                        rec_b.data_byte = in_byte;
                end
                else
                    rec_b.rec_kind = K_TRUNC;
            end
            phase_next     = PH_FIXED;
            offset_next    = '0;
            shift_next     = '0;
            seq_next       = '0;
            stamp_next     = '0;
            first_next     = '0;
            csrc_left_next = '0;
            ext_left_next  = '0;
            elem_left_next = '0;
            stopped_next   = 1'b0;
        end
    end

    // pack the records so the first slot is always filled
    assign have_first = has_a || has_b;
    assign n_any      = have_first;
    always_comb
    begin
        pr.first        = has_a ? rec_a : rec_b;
        pr.second       = rec_b;
        pr.second_valid = has_a && has_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_FIXED;
            offset_reg    <= '0;
            shift_reg     <= '0;
            seq_reg       <= '0;
            stamp_reg     <= '0;
            first_reg     <= '0;
            csrc_left_reg <= '0;
            ext_left_reg  <= '0;
            elem_left_reg <= '0;
            stopped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go)
            begin
                phase_reg     <= phase_next;
                offset_reg    <= offset_next;
                shift_reg     <= shift_next;
                seq_reg       <= seq_next;
                stamp_reg     <= stamp_next;
                first_reg     <= first_next;
                csrc_left_reg <= csrc_left_next;
                ext_left_reg  <= ext_left_next;
                elem_left_reg <= elem_left_next;
                stopped_reg   <= stopped_next;
                out_valid_reg <= n_any;
            end
            else if (pair_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
            out_reg <= pr;
    end

endmodule

[sv/rtph_back.sv]
module rtph_back
    import rtph_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pair_valid,
    output logic        pair_ready,
    input  pair_t       pair_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [3:0]  rec_kind,
    output logic        extension_flag,
    output logic [3:0]  csrc_count,
    output logic        marker,
    output logic [6:0]  payload_type,
    output logic [15:0] sequence_res,
    output logic [31:0] timestamp,
    output logic [31:0] source_id,
    output logic [3:0]  ext_id,
    output logic [4:0]  ext_len,
    output logic [7:0]  data_byte,
    output logic        last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    pair_t           mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]     count_reg;
    logic            half_reg;      // first record of head word already sent
    logic            push, pop;
    pair_t           head;
    rec_t            cur;
    logic            cur_last;

    assign pair_ready = (count_reg != DEPTH[AW:0]);
    assign push       = pair_valid && pair_ready;
    assign head       = mem[rd_ptr_reg];
    assign out_valid  = (count_reg != '0);
    assign cur        = half_reg ? head.second : head.first;
    assign cur_last   = half_reg || !head.second_valid;
    assign pop        = out_valid && out_ready && cur_last;

    assign rec_kind       = cur.rec_kind;
    assign extension_flag = cur.extension_flag;
    assign csrc_count     = cur.csrc_count;
    assign marker         = cur.marker;
    assign payload_type   = cur.payload_type;
    assign sequence_res   = cur.sequence_res;
    assign timestamp      = cur.timestamp;
    assign source_id      = cur.source_id;
    assign ext_id         = cur.ext_id;
    assign ext_len        = cur.ext_len;
    assign data_byte      = cur.data_byte;
    assign last           = cur_last;

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= pair_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            half_reg   <= 1'b0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
            if (out_valid && out_ready)
                half_reg <= !cur_last;
        end
    end

endmodule

[sv/rtph_checker.sv]
module rtph_checker
    import rtph_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [3:0] rec_kind,
    input logic [7:0] data_byte,
    input logic       last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(rec_kind))
        else $error("output word dropped while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> rec_kind <= K_TRUNC)
        else $error("record kind out of range");

    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (rec_kind == K_END || rec_kind == K_TRUNC) |-> last)
        else $error("end record not last");

    a_trunc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && rec_kind == K_TRUNC |-> data_byte == 8'd0)
        else $error("truncated record carries data");

endmodule

bind rtp_header_parser rtph_checker u_rtph_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .rec_kind  (rec_kind),
    .data_byte (data_byte),
    .last      (last)
);

[dv/rtp_header_parser_tb.sv]
module rtp_header_parser_tb;
    import rtph_pkg::*;

    typedef enum logic [3:0] {
        PH_FIXED, PH_CSRC, PH_EXTHDR, PH_ELEM, PH_EDATA, PH_PAYLOAD, PH_DROP
    } phase_e;

    typedef struct {
        rec_t rec;
        logic last;
    } rec_exp_t;

    class rtp_scoreboard;
        rec_exp_t pending[$];
        int errors;
        phase_e phase;
        logic [3:0] offset;
        logic [31:0] shreg;
        logic [15:0] seq_q;
        logic [31:0] stamp_q;
        logic [15:0] first_q;
        logic [3:0] csrc_left;
        logic [17:0] ext_left;
        logic [4:0] elem_left;
        logic stopped;

        function void clear();
            phase = PH_FIXED;
            offset = 0;
            shreg = 0;
            seq_q = 0;
            stamp_q = 0;
            first_q = 0;
            csrc_left = 0;
            ext_left = 0;
            elem_left = 0;
            stopped = 0;
        endfunction

        function void push_rec(rec_t r);
            rec_exp_t e;
            e.rec = r;
            e.last = 0;
            pending.push_back(e);
        endfunction

        function phase_e after_csrc();
            return first_q[12] ? PH_EXTHDR : PH_PAYLOAD;
        endfunction

        // advance parser state by one accepted word
        function void note_word(logic [7:0] b, logic eop);
            phase_e prior;
            logic bad;
            int base;
            rec_t r;
            prior = phase;
            bad = 0;
            base = pending.size();
            r = '0;
            case (prior)
                PH_FIXED:
                begin
                    shreg = {shreg[23:0], b};
                    if (offset == 0 && b[7:6] != 2'd2)
                    begin
                        r.rec_kind = K_BADVER;
                        push_rec(r);
                        phase = PH_DROP;
                        bad = 1;
                    end
                    else
                    begin
                        if (offset == 1) first_q = shreg[15:0];
                        if (offset == 3) seq_q = shreg[15:0];
                        if (offset == 7) stamp_q = shreg;
                        if (offset >= 11)
                        begin
                            r.rec_kind = K_HEADER;
                            r.extension_flag = first_q[12];
                            r.csrc_count = first_q[11:8];
                            r.marker = first_q[7];
                            r.payload_type = first_q[6:0];
                            r.sequence_res = seq_q;
                            r.timestamp = stamp_q;
                            r.source_id = shreg;
                            push_rec(r);
                            csrc_left = first_q[11:8];
                            offset = 0;
                            phase = (csrc_left != 0) ? PH_CSRC : after_csrc();
                        end
                        else offset++;
                    end
                end
                PH_CSRC:
                begin
                    shreg = {shreg[23:0], b};
                    if (offset >= 3)
                    begin
                        r.rec_kind = K_CSRC;
                        r.source_id = shreg;
                        push_rec(r);
                        csrc_left--;
                        offset = 0;
                        if (csrc_left == 0) phase = after_csrc();
                    end
                    else offset++;
                end
                PH_EXTHDR:
                begin
                    shreg = {shreg[23:0], b};
                    if (offset == 1 && shreg[15:0] != EXT_PROFILE)
                    begin
                        r.rec_kind = K_BADPROF;
                        push_rec(r);
                        phase = PH_DROP;
                        bad = 1;
                    end
                    else if (offset >= 3)
                    begin
                        ext_left = {shreg[15:0], 2'b00};
                        offset = 0;
                        stopped = 0;
                        phase = (ext_left != 0) ? PH_ELEM : PH_PAYLOAD;
                    end
                    else offset++;
                end
                PH_ELEM:
                begin
                    ext_left--;
                    if (!stopped)
                    begin
                        if (b[7:4] == 4'hf) stopped = 1;
                        else if (b[7:4] != 0)
                        begin
                            r.rec_kind = K_ELEM;
                            r.ext_id = b[7:4];
                            r.ext_len = {1'b0, b[3:0]} + 5'd1;
                            push_rec(r);
                            elem_left = {1'b0, b[3:0]} + 5'd1;
                            phase = PH_EDATA;
                        end
                    end
                    if (ext_left == 0) phase = PH_PAYLOAD;
                end
                PH_EDATA:
                begin
                    r.rec_kind = K_EBYTE;
                    r.data_byte = b;
                    push_rec(r);
                    ext_left--;
                    elem_left--;
                    if (ext_left == 0) phase = PH_PAYLOAD;
                    else if (elem_left == 0) phase = PH_ELEM;
                end
                PH_PAYLOAD:
                begin
                    r.rec_kind = K_PAY;
                    r.data_byte = b;
                    push_rec(r);
                end
                default: ;
            endcase
            if (eop)
            begin
                if (!bad && prior != PH_DROP)
                begin
                    r = '0;
                    if (phase == PH_PAYLOAD)
                    begin
                        r.rec_kind = K_END;
                        if (first_q[13] && prior == PH_PAYLOAD) r.data_byte = b;
                    end
                    else r.rec_kind = K_TRUNC;
                    push_rec(r);
                end
                clear();
            end
            if (pending.size() > base) pending[pending.size() - 1].last = 1;
        endfunction

        function void check_rec(rec_t got, logic got_last);
            rec_exp_t e;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected record kind %0d", $time, got.rec_kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got !== e.rec || got_last !== e.last)
            begin
                $display("%0t: record mismatch expected %h last %b actual %h last %b",
                    $time, e.rec, e.last, got, got_last);
                errors++;
            end
        endfunction
    endclass

    logic clk, rst_n, in_valid, in_ready, end_of_packet, out_valid, out_ready;
    logic [7:0] in_byte;
    rec_t got;
    logic last;
    rtp_scoreboard sb;
    int cycles;
    int stall_hold;
    bit rx_idle_on;
    logic [7:0] pkt[$];

    rtp_header_parser DUT (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .in_byte(in_byte), .end_of_packet(end_of_packet),
        .out_valid(out_valid), .out_ready(out_ready),
        .rec_kind(got.rec_kind), .extension_flag(got.extension_flag),
        .csrc_count(got.csrc_count), .marker(got.marker),
        .payload_type(got.payload_type), .sequence_res(got.sequence_res),
        .timestamp(got.timestamp), .source_id(got.source_id),
        .ext_id(got.ext_id), .ext_len(got.ext_len),
        .data_byte(got.data_byte), .last(last)
    );

    always
    begin
        clk = 0;
        #10;
        clk = 1;
        #10;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && out_valid && out_ready) sb.check_rec(got, last);

    // receiver: random stalls, plus a long hold-off when requested
    initial
    begin
        int w;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_hold > 0)
            begin
                out_ready <= 0;
                stall_hold--;
            end
            else
            begin
                w = rx_idle_on ? $urandom_range(0, 3) : 0;
                out_ready <= (w == 0);
            end
        end
    end

    // valid stays high after a word so the next one can follow at once
    task automatic send_word(logic [7:0] b, logic eop, bit gaps);
        int w;
        w = gaps ? $urandom_range(0, 3) : 0;
        if (w > 0)
        begin
            in_valid <= 0;
            repeat (w) @(negedge clk);
        end
        in_valid <= 1;
        in_byte <= b;
        end_of_packet <= eop;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_word(b, eop);
        @(negedge clk);
    endtask

    task automatic send_pkt(bit gaps);
        foreach (pkt[i]) send_word(pkt[i], i == pkt.size() - 1, gaps);
    endtask

    // builds a well-formed packet with random content
    task automatic build_pkt(int cc, bit xf, bit pad, int ext_words, int pay_len);
        logic [7:0] hb;
        int i, n;
        pkt.delete();
        hb = {2'b10, pad, xf, cc[3:0]};
        pkt.push_back(hb);
        for (i = 1; i < 12 + 4 * cc; i++) pkt.push_back(8'($urandom));
        if (xf)
        begin
            pkt.push_back(8'hBE);
            pkt.push_back(8'hDE);
            pkt.push_back(8'(ext_words >> 8));
            pkt.push_back(ext_words[7:0]);
            n = ext_words * 4;
            for (i = 0; i < n; i++)
            begin
                case ($urandom_range(0, 9))
                    0: pkt.push_back({4'h0, 4'($urandom)});
                    1: pkt.push_back({4'hf, 4'($urandom)});
                    default: pkt.push_back(8'($urandom));
                endcase
            end
        end
        for (i = 0; i < pay_len; i++) pkt.push_back(8'($urandom));
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    initial
    begin
        int k, cut;
        sb = new();
        sb.clear();
        cycles = 0;
        stall_hold = 0;
        rx_idle_on = 0;
        rst_n = 0;
        in_valid = 0;
        in_byte = 0;
        end_of_packet = 0;
        repeat (11) @(negedge clk);
        rst_n = 1;
        @(negedge clk);

        // directed: plain, max csrc, extension with padding bit, bad cases
        build_pkt(0, 0, 0, 0, 3);
        send_pkt(0);
        build_pkt(15, 1, 1, 2, 2);
        pkt[12 + 60 + 4] = 8'h1f;
        pkt[12 + 60 + 5] = 8'h00;
        pkt[12 + 60 + 6] = 8'hf0;
        send_pkt(0);
        pkt = '{8'h40, 8'hff, 8'h00};
        send_pkt(0);
        pkt = '{8'h90, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h12, 8'h34, 8'h00};
        send_pkt(0);
        build_pkt(0, 1, 0, 0, 0);
        send_pkt(0);
        pkt = '{8'h80, 8'hff, 8'hff};
        send_pkt(0);
        build_pkt(0, 1, 1, 1, 1);
        pkt[16] = 8'hef;
        send_pkt(0);
        drain();

        // long receiver hold-off while input keeps coming
        stall_hold = 60;
        build_pkt(1, 0, 0, 0, 20);
        send_pkt(0);
        drain();

        rx_idle_on = 1;
        k = 0;
        while (k < 1700)
        begin
            build_pkt($urandom_range(0, 3), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)), $urandom_range(0, 3), $urandom_range(0, 6));
            case ($urandom_range(0, 9))
                0: pkt[0] = 8'($urandom);
                1: if (pkt.size() > 14 && pkt[0][4]) pkt[12 + 4 * pkt[0][3:0]] = 8'($urandom);
                2:
                begin
                    cut = $urandom_range(1, pkt.size());
                    while (pkt.size() > cut) void'(pkt.pop_back());
                end
                default: ;
            endcase
            send_pkt($urandom_range(0, 3) != 0);
            k += pkt.size();
            if ($urandom_range(0, 30) == 0) drain();
            if ($urandom_range(0, 15) == 0) rx_idle_on = !rx_idle_on;
        end

        drain();
        repeat (20) @(negedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
